@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the window reduction unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside of reset.
`define PRR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside of reset.
`define PRR_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/prr_pkg.sv @@
// ----------------------------------------------------------------------------
// prr_pkg
// Types and constants shared by the window reduction unit.
// ----------------------------------------------------------------------------
package prr_pkg;

  localparam int FIELD_BITS  = 31;
  localparam int NEWLY_BITS  = 16;
  localparam int DELIV_BITS  = 32;
  localparam int CNT_BITS    = 33;
  localparam int RADIX_BITS  = 2;

  localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;
  localparam logic [CNT_BITS-1:0]   CNT_MAX   = '1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } prr_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELECT,
    ST_MUL,
    ST_BIAS,
    ST_DIV,
    ST_SUB,
    ST_WRITE
  } prr_state_t;

  typedef struct packed {
    logic [1:0]            command;
    logic [FIELD_BITS-1:0] current_window;
    logic [FIELD_BITS-1:0] new_threshold;
    logic                  load_threshold;
    logic                  ecn_capable;
    logic [NEWLY_BITS-1:0] newly_delivered;
    logic [FIELD_BITS-1:0] packets_in_flight;
    logic [FIELD_BITS-1:0] sent_in_recovery;
    logic                  fast_retransmit;
    logic                  in_cwr_state;
    logic                  undo_pending;
  } prr_req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] window_out;
    logic                  window_written;
    logic [FIELD_BITS-1:0] threshold_out;
    logic                  cwr_queued;
    logic                  reduction_complete;
  } prr_rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic sel;
    logic mul;
    logic bias;
    logic div_step;
    logic sub;
    logic load_out;
  } prr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ack;
    logic proportional;
  } prr_sts_t;

endpackage

@@ rtl/core/prr_chan_if.sv @@
// ----------------------------------------------------------------------------
// prr_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface prr_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/prr_ctrl.sv @@
// ----------------------------------------------------------------------------
// prr_ctrl
// Sequencer for the window reduction unit: steps one event through the
// datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prr_ctrl #(
  parameter int DIV_CYCLES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  prr_pkg::prr_sts_t sts,
  output prr_pkg::prr_cmd_t cmd
);
  import prr_pkg::*;

  localparam int CW = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  prr_state_t     state;
  prr_state_t     state_next;
  logic [CW-1:0]  div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.bias) begin
        div_cnt <= CW'(DIV_CYCLES - 1);
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = sts.ack ? ST_SELECT : ST_WRITE;
        end
      end
      ST_SELECT: state_next = sts.proportional ? ST_MUL : ST_WRITE;
      ST_MUL:    state_next = ST_BIAS;
      ST_BIAS:   state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_SUB;
        end
      end
      ST_SUB:    state_next = ST_WRITE;
      ST_WRITE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready    = (state == ST_IDLE);
    cmd          = '0;
    cmd.capture  = (state == ST_IDLE) && req_valid;
    cmd.sel      = (state == ST_SELECT);
    cmd.mul      = (state == ST_MUL);
    cmd.bias     = (state == ST_BIAS);
    cmd.div_step = (state == ST_DIV);
    cmd.sub      = (state == ST_SUB);
    // The result register is loaded only once the previous result has left.
    cmd.load_out = (state == ST_WRITE) && (!rsp_valid || rsp_ready);
  end

  `PRR_ASSERT_NXT(a_div_exit, clk, rst, (state == ST_DIV) && (div_cnt == '0), state == ST_SUB, "divider did not finish after its last step")
  `PRR_ASSERT_NXT(a_ack_select, clk, rst, req_valid && req_ready && sts.ack, state == ST_SELECT, "ack transfer did not enter the select step")
  `PRR_ASSERT_NXT(a_write_done, clk, rst, (state == ST_WRITE) && (!rsp_valid || rsp_ready), (state == ST_IDLE) && rsp_valid, "result was not presented after the write step")

endmodule

@@ rtl/core/prr_dp.sv @@
// ----------------------------------------------------------------------------
// prr_dp
// Datapath of the window reduction unit: reduction state, the slow-start
// bound, a multiplier and a radix-4 restoring divider for the proportional
// count, and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prr_dp #(
  parameter int WINDOW_BITS = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  prr_pkg::prr_cmd_t cmd,
  output prr_pkg::prr_sts_t sts,
  input  prr_pkg::prr_req_t req_data,
  output prr_pkg::prr_rsp_t rsp_data
);
  import prr_pkg::*;

  localparam int W          = WINDOW_BITS;
  localparam int PROD_BITS  = W + DELIV_BITS;
  localparam int DIV_CYCLES = (PROD_BITS + RADIX_BITS - 1) / RADIX_BITS;
  localparam int DIV_BITS   = DIV_CYCLES * RADIX_BITS;
  localparam int SS_BITS    = DELIV_BITS + 2;
  localparam logic [W-1:0] WMASK = '1;

  // Reduction state.
  logic [W-1:0]          prior;
  logic [DELIV_BITS-1:0] deliv;
  logic [W-1:0]          thr;

  // Captured event fields.
  logic [1:0]            op_r;
  logic [NEWLY_BITS-1:0] newly_r;
  logic [W-1:0]          inflight_r;
  logic [W-1:0]          sent_r;
  logic                  fr_r;
  logic                  ecn_r;
  logic                  cwr_st_r;
  logic                  undo_r;

  // Working registers.
  logic [PROD_BITS-1:0]  prod;
  logic [DIV_BITS-1:0]   quo;
  logic [W-1:0]          rem;
  logic [CNT_BITS-1:0]   cnt;

  logic [W-1:0]          divisor;
  logic [DELIV_BITS:0]   deliv_sum;
  logic [W-1:0]          delta;
  logic signed [SS_BITS-1:0] diff;
  logic signed [SS_BITS-1:0] newly_s;
  logic signed [SS_BITS-1:0] m;
  logic [SS_BITS-1:0]    bound;
  logic [SS_BITS-1:0]    delta_x;
  logic [CNT_BITS-1:0]   ss_cnt;
  logic [W-1:0]          r;
  logic [DIV_BITS-1:0]   qv;
  logic [W:0]            trial;
  logic [W-1:0]          rem_next;
  logic [DIV_BITS-1:0]   quo_next;
  logic [DIV_BITS-1:0]   qdiff;
  logic [CNT_BITS-1:0]   prop_cnt;
  logic [CNT_BITS-1:0]   cnt_f;
  logic [CNT_BITS:0]     win_sum;
  logic [W-1:0]          ack_win;
  prr_rsp_t              rsp_next;

  function automatic logic [FIELD_BITS-1:0] clamp_field(input logic [W-1:0] v);
    logic [DELIV_BITS:0] x;
    x = (DELIV_BITS + 1)'(v);
    return (x > (DELIV_BITS + 1)'(FIELD_MAX)) ? FIELD_MAX : x[FIELD_BITS-1:0];
  endfunction

  assign divisor   = (prior == '0) ? W'(1) : prior;
  assign deliv_sum = (DELIV_BITS + 1)'(deliv) + (DELIV_BITS + 1)'(req_data.newly_delivered);

  assign sts.ack          = (req_data.command == CMD_ACK);
  assign sts.proportional = (inflight_r > thr);

  // Slow-start bound: min(thr - inflight, max(delivered - sent, newly) + 1).
  always_comb begin
    delta   = thr - inflight_r;
    diff    = signed'(SS_BITS'(deliv)) - signed'(SS_BITS'(sent_r));
    newly_s = signed'(SS_BITS'(newly_r));
    m       = (diff > newly_s) ? diff : newly_s;
    bound   = unsigned'(m) + SS_BITS'(1);
    delta_x = SS_BITS'(delta);
    ss_cnt  = CNT_BITS'((delta_x < bound) ? delta_x : bound);
  end

  // Two restoring division steps per cycle; quotient bits shift into quo.
  always_comb begin
    r  = rem;
    qv = quo;
    for (int i = 0; i < RADIX_BITS; i++) begin
      trial = {r, qv[DIV_BITS-1]};
      if (trial >= {1'b0, divisor}) begin
        r  = W'(trial - {1'b0, divisor});
        qv = {qv[DIV_BITS-2:0], 1'b1};
      end else begin
        r  = trial[W-1:0];
        qv = {qv[DIV_BITS-2:0], 1'b0};
      end
    end
    rem_next = r;
    quo_next = qv;
  end

  always_comb begin
    qdiff = quo - DIV_BITS'(sent_r);
    if (quo <= DIV_BITS'(sent_r)) begin
      prop_cnt = '0;
    end else if (qdiff > DIV_BITS'(CNT_MAX)) begin
      prop_cnt = CNT_MAX;
    end else begin
      prop_cnt = CNT_BITS'(qdiff);
    end
  end

  always_comb begin
    cnt_f   = (fr_r && (cnt == '0)) ? CNT_BITS'(1) : cnt;
    win_sum = (CNT_BITS + 1)'(inflight_r) + (CNT_BITS + 1)'(cnt_f);
    ack_win = (win_sum > (CNT_BITS + 1)'(WMASK)) ? WMASK : win_sum[W-1:0];

    rsp_next                    = '0;
    rsp_next.threshold_out      = clamp_field(thr);
    case (op_r)
      CMD_START: rsp_next.cwr_queued = ecn_r;
      CMD_ACK: begin
        rsp_next.window_out     = clamp_field(ack_win);
        rsp_next.window_written = 1'b1;
      end
      CMD_END: begin
        // An undo only restores a finite threshold.
        if (cwr_st_r || (undo_r && (thr != WMASK))) begin
          rsp_next.window_out     = clamp_field(thr);
          rsp_next.window_written = 1'b1;
        end
        rsp_next.reduction_complete = 1'b1;
      end
      default: rsp_next.window_written = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior <= '0;
      deliv <= '0;
      thr   <= WMASK;
    end else if (cmd.capture) begin
      case (req_data.command)
        CMD_START: begin
          prior <= W'(req_data.current_window);
          deliv <= '0;
          if (req_data.load_threshold) begin
            thr <= W'(req_data.new_threshold);
          end
        end
        CMD_ACK: deliv <= deliv_sum[DELIV_BITS] ? '1 : deliv_sum[DELIV_BITS-1:0];
        default: deliv <= deliv;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= req_data.command;
      newly_r    <= req_data.newly_delivered;
      inflight_r <= W'(req_data.packets_in_flight);
      sent_r     <= W'(req_data.sent_in_recovery);
      fr_r       <= req_data.fast_retransmit;
      ecn_r      <= req_data.ecn_capable;
      cwr_st_r   <= req_data.in_cwr_state;
      undo_r     <= req_data.undo_pending;
      cnt        <= '0;
    end
    if (cmd.sel) begin
      cnt <= ss_cnt;
    end
    if (cmd.mul) begin
      prod <= PROD_BITS'(thr) * PROD_BITS'(deliv);
    end
    if (cmd.bias) begin
      // Adding divisor - 1 turns the floor quotient into a ceiling.
      quo <= DIV_BITS'(prod + PROD_BITS'(divisor - W'(1)));
      rem <= '0;
    end
    if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
    if (cmd.sub) begin
      cnt <= prop_cnt;
    end
    if (cmd.load_out) begin
      rsp_data <= rsp_next;
    end
  end

  `PRR_ASSERT_IMP(a_rem_below_div, clk, rst, cmd.div_step, rem < divisor, "divider remainder reached the divisor")

endmodule

@@ rtl/core/prr_window_reduction_unit.sv @@
// ----------------------------------------------------------------------------
// prr_window_reduction_unit
// Congestion-window reduction engine: start and ack events update the
// reduction state, and every event yields one result.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload               Meaning
//  req      in   prr_pkg::prr_req_t    one event (start, ack or end)
//  rsp      out  prr_pkg::prr_rsp_t    one result per event
//
// Start, end and unused events go from capture straight to the write step;
// a slow-start ack passes the select step first. A proportional ack passes
// select, multiply, bias, the radix-4 divider that retires two quotient
// bits a cycle, and subtract. One event is in the unit at a time; a new event
// is taken while the previous result still waits in the output register.
// Reset is synchronous; a stalled output holds the unit in its write step.
// ----------------------------------------------------------------------------
module prr_window_reduction_unit #(
  parameter int WINDOW_BITS = 31
) (
  input logic        clk,
  input logic        rst,
  prr_chan_if.sink   req,
  prr_chan_if.source rsp
);
  import prr_pkg::*;

  localparam int DIV_CYCLES = (WINDOW_BITS + DELIV_BITS + RADIX_BITS - 1) / RADIX_BITS;

  prr_cmd_t cmd;
  prr_sts_t sts;

  prr_ctrl #(
    .DIV_CYCLES(DIV_CYCLES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prr_dp #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .req_data(req.data),
    .rsp_data(rsp.data)
  );

endmodule
